>>> hw/rtl/jfdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the joystick frame drive mixer: frame record type, back-end state
// encoding, frame marker constants and the mixing constants. No dependencies.
package jfdm_pkg;

    // Six-byte receive window and the frame markers.
    localparam int WIN_LEN = 6;
    localparam logic [7:0] START_MASK = 8'hF8;
    localparam logic [7:0] START_CODE = 8'hA8;
    localparam logic [7:0] END_MASK   = 8'h1F;
    localparam logic [7:0] END_CODE   = 8'h15;

    // Button bit positions within the end byte.
    localparam int NORTH_BIT  = 7;
    localparam int BUMP_R_BIT = 6;
    localparam int BUMP_L_BIT = 5;

    // Reset value of the dead band register.
    localparam logic [7:0] DEAD_BAND_RESET = 8'd15;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Division by ten: floor(n / 10) = (n * 6554) >> 16 for n up to 3315.
    localparam logic [12:0] DIV10_RECIP = 13'd6554;
    // Division by 255: floor(t / 255) = (t * 263173) >> 26 for t below 2^18.
    localparam logic [18:0] DIV255_RECIP = 19'd263173;

    // Side factor numerator base: 1.6 * 510 less the 255 offset carried by x.
    localparam logic signed [10:0] FACTOR_BASE = 11'sd561;
    // Upper cap of the mixed drive value.
    localparam logic [8:0] DRIVE_CAP = 9'd255;

    // One decoded frame as it travels from the front to the back end.
    typedef struct packed {
        logic [7:0] stick_x;
        logic [7:0] stick_ly;
        logic [7:0] stick_ry;
        logic       north;
        logic       bump_r;
        logic       bump_l;
    } t_frame;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_MUL,
        BK_SCALE
    } t_back_state;

    // A value strictly inside the dead band is forced to zero.
    function automatic logic signed [9:0] apply_band(input logic signed [9:0] v,
                                                     input logic [7:0] db);
        logic signed [9:0] dbs;
        dbs = $signed({2'b00, db});
        if ((v > -dbs) && (v < dbs)) begin
            return 10'sd0;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/jfdm_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for received bytes and drive results.
// Depends on nothing.
interface jfdm_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface jfdm_drive_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] left_drive;
    logic signed [9:0] right_drive;
    logic              tank_active;
    logic              dig_left_on;
    logic              dig_right_on;

    modport source (output valid, output left_drive, output right_drive,
                    output tank_active, output dig_left_on, output dig_right_on,
                    input ready);
    modport sink   (input valid, input left_drive, input right_drive,
                    input tank_active, input dig_left_on, input dig_right_on,
                    output ready);
endinterface
`default_nettype wire

>>> hw/rtl/jfdm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: slides the six-byte window over received bytes and detects frames.
// Depends on jfdm_pkg and jfdm_rx_if.
module jfdm_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    jfdm_rx_if.sink             i_rx,
    input  wire logic           i_full,
    output logic                o_push,
    output jfdm_pkg::t_frame    o_frame
);
    import jfdm_pkg::*;

    logic [7:0] r_win [WIN_LEN];
    logic [7:0] n_win [WIN_LEN];
    logic [2:0] r_held;
    logic [2:0] n_held;
    logic       accept;
    logic       frame_hit;

    // A byte is taken whenever the queue has room for a possible frame.
    assign i_rx.ready = !i_full;
    assign accept     = i_rx.valid && !i_full;

    // Window after this byte: fill while partial, otherwise drop the oldest.
    always_comb begin
        n_win  = r_win;
        n_held = r_held;
        if (r_held < 3'(WIN_LEN)) begin
            n_win[r_held] = i_rx.rx_byte;
            n_held        = r_held + 3'd1;
        end else begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_win[WIN_LEN - 1] = i_rx.rx_byte;
        end
    end

    // Frame check on the full window.
    assign frame_hit = accept && (n_held == 3'(WIN_LEN))
                       && ((n_win[0] & START_MASK) == START_CODE)
                       && ((n_win[WIN_LEN - 1] & END_MASK) == END_CODE);

    assign o_push           = frame_hit;
    assign o_frame.stick_x  = n_win[1];
    assign o_frame.stick_ly = n_win[2];
    assign o_frame.stick_ry = n_win[3];
    assign o_frame.north    = n_win[WIN_LEN - 1][NORTH_BIT];
    assign o_frame.bump_r   = n_win[WIN_LEN - 1][BUMP_R_BIT];
    assign o_frame.bump_l   = n_win[WIN_LEN - 1][BUMP_L_BIT];

    // Fill count; a frame empties the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 3'd0;
        end else if (accept) begin
            r_held <= frame_hit ? 3'd0 : n_held;
        end
    end

    // Window bytes are always written before they are examined.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/jfdm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short frame queue between the front and back ends.
// Depends on jfdm_pkg.
module jfdm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire jfdm_pkg::t_frame i_frame,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output jfdm_pkg::t_frame      o_frame
);
    import jfdm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_frame = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/jfdm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: mode and digger state, tank or arcade mixing in sequenced steps,
// and the result register. Depends on jfdm_pkg and jfdm_drive_if.
module jfdm_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [7:0]       i_dead_band,
    input  wire logic             i_empty,
    input  wire jfdm_pkg::t_frame i_frame,
    output logic                  o_pop,
    jfdm_drive_if.source          o_drive
);
    import jfdm_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    // Mode and digger state.
    logic r_tank;
    logic r_prev_north;
    logic r_dig_l;
    logic r_dig_r;
    logic n_tank;
    logic n_dig_l;
    logic n_dig_r;

    // Datapath registers.
    logic signed [8:0]  r_x;
    logic signed [8:0]  r_y;
    logic signed [9:0]  r_tank_l;
    logic signed [9:0]  r_tank_r;
    logic [11:0]        r_absn;
    logic               r_neg;
    logic signed [9:0]  r_p;
    logic [8:0]         r_absp;
    logic [9:0]         r_fac;
    logic               r_sel_l;
    logic               r_sel_r;
    logic [17:0]        r_m;

    // Result register.
    logic               r_ovalid;
    logic signed [9:0]  r_left;
    logic signed [9:0]  r_right;
    logic               r_otank;
    logic               r_odig_l;
    logic               r_odig_r;

    // Combinational intermediates.
    logic               load;
    logic               out_free;
    logic               emit;
    logic signed [9:0]  x_w;
    logic signed [9:0]  y_w;
    logic signed [12:0] x13;
    logic signed [12:0] y13;
    logic signed [12:0] n_sum;
    logic [12:0]        abs_sum;
    logic [24:0]        prod10;
    logic [8:0]         q10;
    logic [8:0]         capped;
    logic signed [9:0]  x10;
    logic signed [9:0]  db10;
    logic signed [10:0] fac_w;
    logic [18:0]        prod_m;
    logic [35:0]        prod255;
    logic [9:0]         q255;
    logic signed [9:0]  scaled;
    logic signed [9:0]  mix_l;
    logic signed [9:0]  mix_r;

    assign out_free = !r_ovalid || o_drive.ready;
    assign load     = (r_state == BK_IDLE) && !i_empty;
    assign emit     = (r_state == BK_SCALE) && out_free;
    assign o_pop    = load;

    // Sequencer: one frame at a time through the mixing steps.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = BK_PREP;
                end
            end
            BK_PREP:  n_state = BK_DIV;
            BK_DIV:   n_state = BK_MUL;
            BK_MUL:   n_state = BK_SCALE;
            BK_SCALE: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // North edge toggles tank mode; bumpers set or clear the diggers.
    always_comb begin
        n_tank  = r_tank ^ (i_frame.north && !r_prev_north);
        n_dig_l = r_dig_l;
        n_dig_r = r_dig_r;
        if (i_frame.bump_l && i_frame.bump_r) begin
            n_dig_l = 1'b0;
            n_dig_r = 1'b0;
        end else if (i_frame.bump_l) begin
            n_dig_l = 1'b1;
        end else if (i_frame.bump_r) begin
            n_dig_r = 1'b1;
        end else begin
            n_dig_l = 1'b0;
            n_dig_r = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tank       <= 1'b0;
            r_prev_north <= 1'b0;
            r_dig_l      <= 1'b0;
            r_dig_r      <= 1'b0;
        end else if (load) begin
            r_tank       <= n_tank;
            r_prev_north <= i_frame.north;
            r_dig_l      <= n_dig_l;
            r_dig_r      <= n_dig_r;
        end
    end

    // Load step: stick axes and tank drive values.
    assign x_w = $signed({1'b0, i_frame.stick_x, 1'b0}) - 10'sd255;
    assign y_w = 10'sd255 - $signed({1'b0, i_frame.stick_ly, 1'b0});

    // Prep step: magnitude of 10*y + 3*x.
    assign x13     = 13'(r_x);
    assign y13     = 13'(r_y);
    assign n_sum   = (y13 <<< 3) + (y13 <<< 1) + (x13 <<< 1) + x13;
    assign abs_sum = n_sum[12] ? 13'(-n_sum) : 13'(n_sum);

    // Div step: divide by ten, cap above, and pick the side factor.
    assign prod10 = r_absn * DIV10_RECIP;
    assign q10    = prod10[24:16];
    assign capped = (!r_neg && (q10 > DRIVE_CAP)) ? DRIVE_CAP : q10;
    assign x10    = 10'(r_x);
    assign db10   = $signed({2'b00, i_dead_band});
    assign fac_w  = (x10 > db10) ? (FACTOR_BASE - 11'(r_x)) : (FACTOR_BASE + 11'(r_x));

    // Mul step: magnitude of p times the side factor.
    assign prod_m = r_absp * r_fac;

    // Scale step: divide by 510 toward zero and select the sides.
    assign prod255 = r_m[17:1] * DIV255_RECIP;
    assign q255    = prod255[35:26];
    assign scaled  = r_neg ? -$signed(q255) : $signed(q255);
    assign mix_l   = r_sel_l ? scaled : r_p;
    assign mix_r   = r_sel_r ? scaled : r_p;

    // Datapath registers, advanced one step per state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (load) begin
                    r_x      <= 9'(x_w);
                    r_y      <= 9'(apply_band(y_w, i_dead_band));
                    r_tank_l <= apply_band($signed({2'b00, 8'(~i_frame.stick_ly)}),
                                           i_dead_band);
                    r_tank_r <= apply_band($signed({2'b00, 8'(~i_frame.stick_ry)}),
                                           i_dead_band);
                end
            end
            BK_PREP: begin
                r_absn <= abs_sum[11:0];
                r_neg  <= n_sum[12];
            end
            BK_DIV: begin
                r_absp  <= capped;
                r_p     <= r_neg ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
                r_fac   <= fac_w[9:0];
                r_sel_r <= (x10 > db10);
                r_sel_l <= (x10 < -db10);
            end
            BK_MUL: begin
                r_m <= prod_m[17:0];
            end
            default: begin
            end
        endcase
    end

    // Result register: loaded when a frame finishes, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (o_drive.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_left   <= r_tank ? r_tank_l : mix_l;
            r_right  <= r_tank ? r_tank_r : mix_r;
            r_otank  <= r_tank;
            r_odig_l <= r_dig_l;
            r_odig_r <= r_dig_r;
        end
    end

    assign o_drive.valid        = r_ovalid;
    assign o_drive.left_drive   = r_left;
    assign o_drive.right_drive  = r_right;
    assign o_drive.tank_active  = r_otank;
    assign o_drive.dig_left_on  = r_odig_l;
    assign o_drive.dig_right_on = r_odig_r;

endmodule
`default_nettype wire

>>> hw/rtl/joystick_frame_drive_mixer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the joystick frame drive mixer: dead band register, front end,
// frame queue and back end. Depends on jfdm_pkg, jfdm_ifs and the jfdm modules.
//
//  Channel   | Dir | Handshake    | Transaction
//  ----------+-----+--------------+------------------------------------------
//  i_rx      | in  | valid/ready  | one received byte
//  o_drive   | out | valid/ready  | left/right drive, tank mode, digger bits
//  i_cfg_*   | in  | write enable | new dead band value
//
// Every byte is taken while the frame queue has room; a byte that completes a frame
// is pushed into a two-entry queue. The back end takes each frame through its steps in
// order (load, sum, divide by ten, multiply, scale by 1/510) and then waits in its last
// step for the result register to be free; a stalled output only holds the front once
// both queue entries are in use. Reset is synchronous and active low; it empties the
// window, queue and result register and sets the dead band to 15.
module joystick_frame_drive_mixer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    jfdm_rx_if.sink         i_rx,
    jfdm_drive_if.source    o_drive
);
    import jfdm_pkg::*;

    logic [7:0] r_dead_band;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_frame     push_frame;
    t_frame     head_frame;

    // Dead band register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_band <= DEAD_BAND_RESET;
        end else if (i_cfg_we) begin
            r_dead_band <= i_cfg_wdata;
        end
    end

    // Byte window and frame detection.
    jfdm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_full  (full),
        .o_push  (push),
        .o_frame (push_frame)
    );

    // Frames waiting for the mixer.
    jfdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (push_frame),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_frame (head_frame)
    );

    // Mode state, mixing and result register.
    jfdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dead_band (r_dead_band),
        .i_empty     (empty),
        .i_frame     (head_frame),
        .o_pop       (pop),
        .o_drive     (o_drive)
    );

endmodule
`default_nettype wire

>>> sim/joystick_frame_drive_mixer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for joystick_frame_drive_mixer_core: byte stimulus, a frame
// and drive mixing predictor, and a checker on the drive channel.
// Depends on jfdm_pkg, jfdm_ifs and the RTL of the core.
module joystick_frame_drive_mixer_core_tb;
    import jfdm_pkg::*;

    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TIMEOUT_NS      = 4_000_000;

    // One expected drive transaction.
    typedef struct packed {
        logic signed [9:0] left;
        logic signed [9:0] right;
        logic              tank;
        logic              dig_l;
        logic              dig_r;
    } t_mix_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    jfdm_rx_if    rx_ch ();
    jfdm_drive_if drive_ch ();

    joystick_frame_drive_mixer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch.sink),
        .o_drive     (drive_ch.source)
    );

    // Predictor state, mirroring the block after reset.
    logic [7:0]  rx_window [0:WIN_LEN-1];
    int          rx_fill   = 0;
    logic        tank_on   = 1'b0;
    logic        north_last = 1'b0;
    logic        dig_left  = 1'b0;
    logic        dig_right = 1'b0;
    logic [7:0]  band_db   = DEAD_BAND_RESET;

    t_mix_result mix_expect_q [$];
    int          err_count      = 0;
    int          bytes_sent     = 0;
    int          frames_checked = 0;
    int          band_settings  = 1;
    bit          rx_gaps_on     = 1'b1;
    bit          drive_stalls_on = 1'b1;
    bit          hold_off_req   = 1'b0;

    // Clock: 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Zero a value lying strictly inside the dead band.
    function automatic int in_band(input int v);
        int db;
        db = band_db;
        if (v > -db && v < db) begin
            return 0;
        end
        return v;
    endfunction

    // Stick values weighted towards the ends and the centre.
    function automatic logic [7:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(112, 143));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the receive window by one byte and queue a drive result when a frame closes.
    task automatic take_rx_byte(input logic [7:0] b);
        logic [7:0]  fr [0:WIN_LEN-1];
        int          x;
        int          y;
        int          p;
        int          l;
        int          r;
        int          db;
        t_mix_result res;
        if (rx_fill < WIN_LEN) begin
            rx_window[rx_fill] = b;
            rx_fill++;
        end else begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                rx_window[i] = rx_window[i + 1];
            end
            rx_window[WIN_LEN - 1] = b;
        end
        if (rx_fill < WIN_LEN) begin
            return;
        end
        if ((rx_window[0] & START_MASK) != START_CODE ||
            (rx_window[WIN_LEN - 1] & END_MASK) != END_CODE) begin
            return;
        end
        fr = rx_window;
        foreach (rx_window[i]) begin
            rx_window[i] = 8'h00;
        end
        rx_fill = 0;

        // Tank mode flips on a rising edge of the north button.
        if (fr[5][NORTH_BIT] && !north_last) begin
            tank_on = !tank_on;
        end
        north_last = fr[5][NORTH_BIT];

        db = band_db;
        if (tank_on) begin
            l = in_band(255 - int'(fr[2]));
            r = in_band(255 - int'(fr[3]));
        end else begin
            x = 2 * int'(fr[1]) - 255;
            y = in_band(255 - 2 * int'(fr[2]));
            p = (10 * y + 3 * x) / 10;
            if (p > 255) begin
                p = 255;
            end
            l = p;
            r = p;
            if (x > db) begin
                r = (p * (561 - x)) / 510;
            end else if (x < -db) begin
                l = (p * (561 + x)) / 510;
            end
        end

        // Bumpers: one alone latches its digger, both or none clear both.
        if (fr[5][BUMP_L_BIT] && fr[5][BUMP_R_BIT]) begin
            dig_left  = 1'b0;
            dig_right = 1'b0;
        end else if (fr[5][BUMP_L_BIT]) begin
            dig_left = 1'b1;
        end else if (fr[5][BUMP_R_BIT]) begin
            dig_right = 1'b1;
        end else begin
            dig_left  = 1'b0;
            dig_right = 1'b0;
        end

        res.left  = 10'(l);
        res.right = 10'(r);
        res.tank  = tank_on;
        res.dig_l = dig_left;
        res.dig_r = dig_right;
        mix_expect_q.push_back(res);
    endtask

    // Offer one byte, with an occasional idle burst first, and wait for the transaction.
    task automatic send_byte(input logic [7:0] b);
        if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (rx_ch.ready !== 1'b1);
        bytes_sent++;
        take_rx_byte(b);
    endtask

    // A frame with random content; a broken one has a corrupted start or end marker.
    task automatic send_frame(input bit broken);
        logic [7:0] fr [0:WIN_LEN-1];
        fr[0] = START_CODE | 8'($urandom_range(0, 7));
        fr[1] = rand_axis();
        fr[2] = rand_axis();
        fr[3] = rand_axis();
        fr[4] = 8'($urandom_range(0, 255));
        fr[5] = (8'($urandom_range(0, 7)) << 5) | END_CODE;
        if (broken) begin
            if ($urandom_range(0, 1) == 1) begin
                fr[0] ^= 8'(1 << $urandom_range(3, 7));
            end else begin
                fr[5] ^= 8'(1 << $urandom_range(0, 4));
            end
        end
        foreach (fr[i]) begin
            send_byte(fr[i]);
        end
    endtask

    // Mostly good frames, with noise bytes and broken frames mixed in.
    task automatic random_traffic(input int n);
        int stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                1: send_frame(1'b1);
                default: send_frame(1'b0);
            endcase
        end
    endtask

    // Drop valid and wait until every expected transaction has been seen.
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        while (mix_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dead_band(input logic [7:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        band_db = v;
        band_settings++;
        i_cfg_we <= 1'b0;
    endtask

    // Hand-picked frames: caps, negative mixing, tank toggle, bumpers and a resync.
    task automatic test_directed_frames();
        logic [7:0] seq [0:24];
        seq = '{8'hA8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h15,
                8'hA8, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h35,
                8'h3C, 8'hAF, 8'h40, 8'h00, 8'hFF, 8'h80, 8'hD5,
                8'hA9, 8'h7F, 8'h80, 8'h00, 8'hFF, 8'hF5};
        foreach (seq[i]) begin
            send_byte(seq[i]);
        end
    endtask

    task automatic test_zero_band();
        write_dead_band(8'd0);
        random_traffic(120);
    endtask

    task automatic test_full_band();
        write_dead_band(8'd255);
        random_traffic(100);
    endtask

    // Stall the output for a long stretch while bytes keep coming, so the input backs up.
    task automatic test_output_hold_off();
        write_dead_band(8'($urandom_range(1, 254)));
        rx_gaps_on   = 1'b0;
        hold_off_req = 1'b1;
        repeat (8) send_frame(1'b0);
        rx_gaps_on = 1'b1;
    endtask

    // Let everything drain, then resume with idling on both sides.
    task automatic test_pause_and_resume();
        wait_idle();
        random_traffic(250);
    endtask

    task automatic test_steady_stream();
        write_dead_band(8'd1);
        rx_gaps_on      = 1'b0;
        drive_stalls_on = 1'b0;
        random_traffic(120);
    endtask

    // Output readiness: random stalls, or a long hold-off when requested.
    initial begin
        drive_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                drive_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (drive_stalls_on && $urandom_range(0, 5) == 0) begin
                drive_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                drive_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            err_count++;
        end
    endtask

    // Compare every drive transaction with the oldest expectation.
    always @(posedge i_clk) begin : drive_check
        t_mix_result want;
        if (i_rst_n && drive_ch.valid && drive_ch.ready) begin
            if (mix_expect_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual left %0d right %0d",
                         $time, drive_ch.left_drive, drive_ch.right_drive);
                err_count++;
            end else begin
                want = mix_expect_q.pop_front();
                frames_checked++;
                check_field("left_drive", $signed(want.left), drive_ch.left_drive);
                check_field("right_drive", $signed(want.right), drive_ch.right_drive);
                check_field("tank_active", want.tank, drive_ch.tank_active);
                check_field("dig_left_on", want.dig_l, drive_ch.dig_left_on);
                check_field("dig_right_on", want.dig_r, drive_ch.dig_right_on);
            end
        end
    end

    // Main sequence.
    initial begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 8'h00;
        i_rst_n       = 1'b0;
        foreach (rx_window[i]) begin
            rx_window[i] = 8'h00;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_zero_band();
        test_full_band();
        test_output_hold_off();
        test_pause_and_resume();
        test_steady_stream();
        wait_idle();

        $display("Sent %0d bytes and checked %0d drive results over %0d dead band settings.",
                 bytes_sent, frames_checked, band_settings);
        if (err_count == 0 && mix_expect_q.size() == 0) begin
            $display("PASS joystick_frame_drive_mixer_core");
        end else begin
            $display("FAIL joystick_frame_drive_mixer_core");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL joystick_frame_drive_mixer_core");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/jfdm_pkg.sv
hw/rtl/jfdm_ifs.sv
hw/rtl/jfdm_front.sv
hw/rtl/jfdm_queue.sv
hw/rtl/jfdm_back.sv
hw/rtl/joystick_frame_drive_mixer_core.sv
sim/joystick_frame_drive_mixer_core_tb.sv
